// ===== design/ctf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ctf_pkg
// Shared constants, CORDIC arctangent table and cell types for the
// complementary tilt filter.
// ---------------------------------------------------------------------------
package ctf_pkg;

   localparam int CordicStepsDefault = 16;
   localparam int CordicStepsMax     = 24;

   // CORDIC datapath width: 16-bit operand widened by 2^16, plus growth.
   localparam int CW = 36;
   // Angle accumulator width (signed Q11.16 degrees, within +-270).
   localparam int ZW = 27;

   localparam logic [31:0] GyroGainReset = 32'd10240000;
   localparam logic [16:0] MagLowReset   = 17'd8192;
   localparam logic [16:0] MagHighReset  = 17'd32768;

   localparam logic [16:0] WeightOld = 17'd64225;
   localparam logic [16:0] WeightAcc = 17'd1311;
   localparam logic signed [ZW-1:0] Deg90 = ZW'(90 * 65536);

   localparam logic [1:0] RegGyroGain = 2'd0;
   localparam logic [1:0] RegMagLow   = 2'd1;
   localparam logic [1:0] RegMagHigh  = 2'd2;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
   } vec_type;

   function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
      logic signed [ZW-1:0] r;
      case (i)
         5'd0:  r = ZW'(2949120);
         5'd1:  r = ZW'(1740967);
         5'd2:  r = ZW'(919879);
         5'd3:  r = ZW'(466945);
         5'd4:  r = ZW'(234379);
         5'd5:  r = ZW'(117304);
         5'd6:  r = ZW'(58666);
         5'd7:  r = ZW'(29335);
         5'd8:  r = ZW'(14668);
         5'd9:  r = ZW'(7334);
         5'd10: r = ZW'(3667);
         5'd11: r = ZW'(1833);
         5'd12: r = ZW'(917);
         5'd13: r = ZW'(458);
         5'd14: r = ZW'(229);
         5'd15: r = ZW'(115);
         5'd16: r = ZW'(57);
         5'd17: r = ZW'(29);
         5'd18: r = ZW'(14);
         5'd19: r = ZW'(7);
         5'd20: r = ZW'(4);
         5'd21: r = ZW'(2);
         5'd22: r = ZW'(1);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== design/ctf_cordic_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ctf_cordic_cell
// One registered CORDIC vectoring micro-rotation with a fixed shift.
// ---------------------------------------------------------------------------
module ctf_cordic_cell #(
   parameter int STEP = 0
) (
   input  wire logic             clock,
   input  wire ctf_pkg::vec_type vec_in,
   output ctf_pkg::vec_type      vec_out
);
   import ctf_pkg::*;

   vec_type vec_ff, vec_next_in;
   logic signed [CW-1:0] xs, ys;

   always_comb begin
      // Arithmetic shift is a floor shift.
      xs = vec_in.x >>> STEP;
      ys = vec_in.y >>> STEP;
      if (!vec_in.y[CW-1]) begin
         vec_next_in.x = vec_in.x + ys;
         vec_next_in.y = vec_in.y - xs;
         vec_next_in.z = vec_in.z + atan_entry(5'(STEP));
      end else begin
         vec_next_in.x = vec_in.x - ys;
         vec_next_in.y = vec_in.y + xs;
         vec_next_in.z = vec_in.z - atan_entry(5'(STEP));
      end
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_next_in;
   end

   assign vec_out = vec_ff;
endmodule
`default_nettype wire

// ===== design/ctf_cordic_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ctf_cordic_chain
// Pre-rotation and a row of CORDIC cells computing atan2(y, x) in degrees.
// ---------------------------------------------------------------------------
module ctf_cordic_chain #(
   parameter int CORDIC_STEPS = ctf_pkg::CordicStepsDefault
) (
   input  wire logic                        clock,
   input  wire logic signed [15:0]          y_in,
   input  wire logic signed [15:0]          x_in,
   output logic signed [ctf_pkg::ZW-1:0]    angle
);
   import ctf_pkg::*;

   vec_type head;
   vec_type taps [CORDIC_STEPS+1];
   logic signed [CW-1:0] xw, yw;

   always_comb begin
      xw = CW'(x_in) <<< 16;
      yw = CW'(y_in) <<< 16;
      head = '{x: xw, y: yw, z: '0};
      if (x_in[15]) begin
         if (!y_in[15]) head = '{x: yw, y: -xw, z: Deg90};
         else           head = '{x: -yw, y: xw, z: -Deg90};
      end
   end

   assign taps[0] = head;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
      ctf_cordic_cell #(.STEP(g)) u_cell (
         .clock  (clock),
         .vec_in (taps[g]),
         .vec_out(taps[g+1])
      );
   end

   // A zero vector has no direction and reads as zero degrees. The operands
   // are held for the whole pass through the row, so they still apply here.
   assign angle = (x_in == 16'sd0 && y_in == 16'sd0) ? '0 : taps[CORDIC_STEPS].z;
endmodule
`default_nettype wire

// ===== design/complementary_tilt_filter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// complementary_tilt_filter_core
// Complementary pitch/roll filter: gyro integration plus accelerometer blend.
// ---------------------------------------------------------------------------
// Each accepted item passes through S_GYRO, S_SAT and S_WAIT; when the
// blend applies, S_WAIT waits for the CORDIC cell row to settle and S_MUL
// and S_SUM follow, before S_OUT presents the result. One item at a time:
// a new item is taken only in S_IDLE, after the last result was accepted.
// Reset clears the pitch and roll estimates to zero and the registers to
// their defaults; no clearing pass is needed.
module complementary_tilt_filter_core #(
   parameter int CORDIC_STEPS = ctf_pkg::CordicStepsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic signed [15:0] req_accel_x,
   input  wire logic signed [15:0] req_accel_y,
   input  wire logic signed [15:0] req_accel_z,
   input  wire logic signed [15:0] req_gyro_x,
   input  wire logic signed [15:0] req_gyro_y,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [31:0] rsp_pitch_angle,
   output logic signed [31:0] rsp_roll_angle,
   output logic             rsp_accel_applied,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import ctf_pkg::*;

   localparam int CntW = $clog2(CORDIC_STEPS + 8);

   typedef enum logic [2:0] {
      S_IDLE, S_GYRO, S_SAT, S_WAIT, S_MUL, S_SUM, S_OUT
   } state_type;

   state_type state_ff;
   logic [CntW-1:0] cnt_ff;
   logic [31:0] gain_ff;
   logic [16:0] mag_low_ff, mag_high_ff;
   logic signed [31:0] pitch_ff, roll_ff;
   logic signed [15:0] ax_ff, ay_ff, az_ff, gx_ff, gy_ff;
   logic signed [48:0] dp_ff, dr_ff;
   logic apply_ff;
   logic signed [ZW-1:0] pitch_acc, roll_acc;
   logic signed [49:0] mp_old_ff, mr_old_ff, mp_acc_ff, mr_acc_ff;
   logic [1:0] reg_idx;
   logic [17:0] mag;

   function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
      if (v > 51'sd2147483647)       return 32'sh7fffffff;
      else if (v < -51'sd2147483648) return 32'sh80000000;
      else                           return v[31:0];
   endfunction

   function automatic logic [15:0] absv(input logic signed [15:0] v);
      return v[15] ? 16'(-v) : v;
   endfunction

   assign reg_idx = csr_paddr[3:2];
   assign csr_pready = 1'b1;

   always_comb begin
      case (reg_idx)
         RegGyroGain: csr_prdata = gain_ff;
         RegMagLow:   csr_prdata = {15'd0, mag_low_ff};
         RegMagHigh:  csr_prdata = {15'd0, mag_high_ff};
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GyroGainReset;
         mag_low_ff <= MagLowReset;
         mag_high_ff <= MagHighReset;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (reg_idx)
            RegGyroGain: gain_ff <= csr_pwdata;
            RegMagLow:   mag_low_ff <= csr_pwdata[16:0];
            RegMagHigh:  mag_high_ff <= csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   // The CORDIC rows read the held accelerometer item each cycle.
   ctf_cordic_chain #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
      .clock(clock), .y_in(ay_ff), .x_in(az_ff), .angle(pitch_acc));
   ctf_cordic_chain #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
      .clock(clock), .y_in(ax_ff), .x_in(az_ff), .angle(roll_acc));

   assign mag = 18'(absv(ax_ff)) + 18'(absv(ay_ff)) + 18'(absv(az_ff));
   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid <= 1'b0;
         pitch_ff <= '0;
         roll_ff <= '0;
         cnt_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  ax_ff <= req_accel_x;
                  ay_ff <= req_accel_y;
                  az_ff <= req_accel_z;
                  gx_ff <= req_gyro_x;
                  gy_ff <= req_gyro_y;
                  state_ff <= S_GYRO;
               end
            end
            S_GYRO: begin
               dp_ff <= 49'(gx_ff) * $signed({17'd0, gain_ff});
               dr_ff <= 49'(gy_ff) * $signed({17'd0, gain_ff});
               apply_ff <= (18'(mag_low_ff) < mag) && (mag < 18'(mag_high_ff));
               cnt_ff <= '0;
               state_ff <= S_SAT;
            end
            S_SAT: begin
               pitch_ff <= sat32(51'(pitch_ff) + 51'((dp_ff + 49'sd32768) >>> 16));
               roll_ff <= sat32(51'(roll_ff) - 51'((dr_ff + 49'sd32768) >>> 16));
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (!apply_ff) begin
                  state_ff <= S_OUT;
               end else if (cnt_ff == CntW'(CORDIC_STEPS)) begin
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               mp_old_ff <= 50'(pitch_ff) * $signed({1'b0, WeightOld});
               mr_old_ff <= 50'(roll_ff) * $signed({1'b0, WeightOld});
               mp_acc_ff <= 50'(pitch_acc) * $signed({1'b0, WeightAcc});
               mr_acc_ff <= 50'(roll_acc) * $signed({1'b0, WeightAcc});
               state_ff <= S_SUM;
            end
            S_SUM: begin
               pitch_ff <= sat32(51'((mp_old_ff + mp_acc_ff + 50'sd32768) >>> 16));
               roll_ff <= sat32(51'((mr_old_ff + mr_acc_ff + 50'sd32768) >>> 16));
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid) begin
                  rsp_valid <= 1'b1;
                  rsp_pitch_angle <= pitch_ff;
                  rsp_roll_angle <= roll_ff;
                  rsp_accel_applied <= apply_ff;
               end else if (rsp_ready) begin
                  rsp_valid <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== test/tb_complementary_tilt_filter_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_complementary_tilt_filter_core
// Drives IMU samples into the tilt filter, predicts pitch, roll and the
// blend flag for each accepted item, and checks every result in order,
// across several register settings and idle patterns on both channels.
// ---------------------------------------------------------------------------
module tb_complementary_tilt_filter_core;
   import ctf_pkg::*;

   localparam logic [1:0] RegUnused = 2'd3;
   localparam int SettleCycles = 40;
   localparam int StallLimit = 5000;

   typedef struct {
      logic signed [31:0] pitch;
      logic signed [31:0] roll;
      logic applied;
   } tilt_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [15:0] req_accel_x = 0, req_accel_y = 0, req_accel_z = 0;
   logic signed [15:0] req_gyro_x = 0, req_gyro_y = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [31:0] rsp_pitch_angle, rsp_roll_angle;
   logic rsp_accel_applied;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [3:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   // Model copy of the filter state and registers.
   logic signed [31:0] pitch_est, roll_est;
   logic [31:0] gain_reg;
   logic [16:0] low_reg, high_reg;

   tilt_type pending_tilts[$];
   int mismatches = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;

   complementary_tilt_filter_core u_dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic longint tilt_atan2(int yi, int xi);
      longint x, y, z, t, xs, ys;
      x = longint'(xi) * 65536;
      y = longint'(yi) * 65536;
      z = 0;
      if (xi == 0 && yi == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = 90 * 65536;
         end else begin
            x = -y; y = t; z = -90 * 65536;
         end
      end
      for (int i = 0; i < CordicStepsDefault; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += longint'(atan_entry(5'(i)));
         end else begin
            x -= ys; y += xs; z -= longint'(atan_entry(5'(i)));
         end
      end
      return z;
   endfunction

   function automatic logic signed [31:0] blend_toward(logic signed [31:0] est, longint acc);
      longint s;
      s = longint'(est) * 64225 + acc * 1311 + 32768;
      return clamp32(s >>> 16);
   endfunction

   function automatic tilt_type update_tilt(int ax, int ay, int az, int gx, int gy);
      longint dp, dr, g;
      int mag;
      tilt_type r;
      g = longint'(gain_reg);
      dp = (longint'(gx) * g + 32768) >>> 16;
      dr = (longint'(gy) * g + 32768) >>> 16;
      pitch_est = clamp32(longint'(pitch_est) + dp);
      roll_est = clamp32(longint'(roll_est) - dr);
      mag = (ax < 0 ? -ax : ax) + (ay < 0 ? -ay : ay) + (az < 0 ? -az : az);
      r.applied = (mag > int'(low_reg)) && (mag < int'(high_reg));
      if (r.applied) begin
         pitch_est = blend_toward(pitch_est, tilt_atan2(ay, az));
         roll_est = blend_toward(roll_est, tilt_atan2(ax, az));
      end
      r.pitch = pitch_est;
      r.roll = roll_est;
      return r;
   endfunction

   // Receiver stall pattern and result checking.
   always @(posedge clock) begin
      tilt_type e;
      if (!reset) rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_tilts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result pitch=%0d roll=%0d",
                                           rsp_pitch_angle, rsp_roll_angle);
         end else begin
            e = pending_tilts.pop_front();
            if (rsp_pitch_angle !== e.pitch || rsp_roll_angle !== e.roll ||
                rsp_accel_applied !== e.applied) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp pitch=%0d roll=%0d app=%0b got %0d %0d %0b",
                           e.pitch, e.roll, e.applied, rsp_pitch_angle,
                           rsp_roll_angle, rsp_accel_applied);
            end
         end
      end
   end

   // Watchdog on cycles with no accepted item on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("tb_complementary_tilt_filter_core: FAIL");
         $finish;
      end
   end

   task automatic send_sample(int ax, int ay, int az, int gx, int gy);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_accel_x <= 16'(ax);
      req_accel_y <= 16'(ay);
      req_accel_z <= 16'(az);
      req_gyro_x <= 16'(gx);
      req_gyro_y <= 16'(gy);
      // Ready only changes at rising edges, so the falling edge shows
      // whether the coming rising edge accepts the item.
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      pending_tilts.push_back(update_tilt(ax, ay, az, gx, gy));
   endtask

   task automatic wait_idle();
      req_valid <= 0;
      while (pending_tilts.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      case (idx)
         RegGyroGain: gain_reg = value;
         RegMagLow:   low_reg = value[16:0];
         RegMagHigh:  high_reg = value[16:0];
         default: ;
      endcase
   endtask

   task automatic set_regs(logic [31:0] g, logic [16:0] lo, logic [16:0] hi);
      wait_idle();
      write_reg(RegGyroGain, g);
      write_reg(RegMagLow, 32'(lo));
      write_reg(RegMagHigh, 32'(hi));
   endtask

   function automatic int rand_axis(int span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   task automatic test_directed();
      send_sample(0, 0, 0, 0, 0);
      send_sample(32767, 32767, 32767, 32767, 32767);
      send_sample(-32768, -32768, -32768, -32768, -32768);
      // Zero y over a negative z gives a straight 180 degrees.
      send_sample(0, 0, -10000, 0, 0);
      send_sample(3000, -3000, -10000, 100, -100);
      send_sample(-3000, 3000, -10000, -100, 100);
      send_sample(5000, 5000, 0, 1, -1);
      // Magnitude right at, and just inside, each bound.
      send_sample(4000, 4000, 192, 0, 0);
      send_sample(4000, 4000, 193, 0, 0);
      send_sample(16000, 16000, 767, 0, 0);
      send_sample(-16000, 16000, -768, 0, 0);
      // The unused address must not disturb anything.
      wait_idle();
      write_reg(RegUnused, 32'hffffffff);
      send_sample(1000, 2000, 8000, 500, -500);
   endtask

   task automatic test_saturation();
      set_regs(32'hffffffff, 17'd98304, 17'd0);
      repeat (4) send_sample(0, 0, 0, 32767, -32768);
      repeat (4) send_sample(0, 0, 0, -32768, 32767);
      set_regs(GyroGainReset, MagLowReset, MagHighReset);
   endtask

   task automatic test_random(int count, int span);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 70)
            send_sample(rand_axis(span), rand_axis(span), rand_axis(span),
                        rand_axis(2000), rand_axis(2000));
         else
            send_sample(rand_axis(32768) % 32768, rand_axis(32768) % 32768,
                        $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                        $urandom_range(0, 65535) - 32768);
      end
   endtask

   task automatic test_pressure();
      test_random(20, 6000);
      // Hold off until the pipeline has drained completely.
      req_valid <= 0;
      while (pending_tilts.size() != 0) @(posedge clock);
      test_random(20, 6000);
   endtask

   initial begin
      pitch_est = 0;
      roll_est = 0;
      gain_reg = GyroGainReset;
      low_reg = MagLowReset;
      high_reg = MagHighReset;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      test_directed();
      test_saturation();

      send_idle_pct = 0; recv_stall_pct = 0;
      test_random(300, 9000);
      set_regs($urandom, 17'd0, 17'd98304);
      send_idle_pct = 61; recv_stall_pct = 0;
      test_random(300, 30000);
      set_regs(32'd0, 17'd98304, 17'd0);
      send_idle_pct = 0; recv_stall_pct = 61;
      test_random(250, 9000);
      set_regs(32'hffffffff, 17'd20000, 17'd20001);
      send_idle_pct = 32; recv_stall_pct = 32;
      test_random(250, 9000);
      set_regs(GyroGainReset, MagLowReset, MagHighReset);
      test_pressure();
      send_idle_pct = 0; recv_stall_pct = 0;
      test_random(200, 9000);
      send_idle_pct = 32; recv_stall_pct = 61;
      test_random(160, 9000);

      wait_idle();
      if (mismatches == 0) begin
         $display("tb_complementary_tilt_filter_core: PASS");
      end else begin
         $display("tb_complementary_tilt_filter_core: FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/ctf_pkg.sv
design/ctf_cordic_cell.sv
design/ctf_cordic_chain.sv
design/complementary_tilt_filter_core.sv
test/tb_complementary_tilt_filter_core.sv
